### rtl/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestLen  = 8;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;

  typedef enum logic [0:0] {
    OpAbsorb = 1'b0,
    OpFinish = 1'b1
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic       put_byte;    // write byte at fill position
    logic       byte_is_pad; // write 0x80 instead of data
    logic       clr_word;    // zero the word at zero_idx
    logic [3:0] zero_idx;
    logic       put_len;     // write bit length into words 14 and 15
    logic       count_byte;  // advance fill count and byte total
    logic       start_comp;  // load working vars from chaining words
    logic       round;       // run one compression round
    logic       fold;        // add working vars into chaining words
    logic       restart;     // back to initial value
    logic       shift_out;   // rotate chaining words for output
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } stat_t;

  localparam word_t InitH [DigestLen] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam byte_t PadByte  = 8'h80;
  localparam int unsigned LenPos = 56;

endpackage
`default_nettype wire

### rtl/sha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [7:0] data_byte;
  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface sha_out_if;
  logic valid;
  logic ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface
`default_nettype wire

### rtl/sha_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sha_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    byte_i,
  output sha_pkg::stat_t     stat_o,
  output sha_pkg::word_t     head_o
);

  sha_pkg::word_t blk_q [16];
  sha_pkg::word_t h_q [8], h_d [8];
  sha_pkg::word_t v_q [8], v_d [8];
  logic [5:0]  fill_q;
  logic [63:0] total_q;
  logic [5:0]  rnd_q;

  function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // round logic; w schedule is a 16-word rotating window in blk_q
  sha_pkg::word_t w_new, t1, t2, s0, s1, e, a;
  always_comb begin
    s0 = ror(blk_q[1], 7) ^ ror(blk_q[1], 18) ^ (blk_q[1] >> 3);
    s1 = ror(blk_q[14], 17) ^ ror(blk_q[14], 19) ^ (blk_q[14] >> 10);
    w_new = blk_q[0] + s0 + blk_q[9] + s1;
    e = v_q[4];
    a = v_q[0];
    t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
         + sha_pkg::RoundK[rnd_q] + blk_q[0];
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
         + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
    for (int i = 0; i < 8; i++) begin
      v_d[i] = v_q[i];
      h_d[i] = h_q[i];
    end
    if (cmd_i.start_comp) begin
      for (int i = 0; i < 8; i++) v_d[i] = h_q[i];
    end else if (cmd_i.round) begin
      for (int i = 7; i > 0; i--) v_d[i] = v_q[i-1];
      v_d[4] = v_q[3] + t1;
      v_d[0] = t1 + t2;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
    end else if (cmd_i.restart) begin
      for (int i = 0; i < 8; i++) h_d[i] = sha_pkg::InitH[i];
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < 7; i++) h_d[i] = h_q[i+1];
      h_d[7] = h_q[0];
    end
  end

  // block buffer: byte writes, clears, length, schedule rotation
  logic [3:0]    widx;
  logic [1:0]    lane;
  sha_pkg::byte_t bval;
  assign widx = fill_q[5:2];
  assign lane = fill_q[1:0];
  assign bval = cmd_i.byte_is_pad ? sha_pkg::PadByte : byte_i;
  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
      blk_q[15] <= w_new;
    end else begin
      if (cmd_i.put_byte) begin
        unique case (lane)
          2'd0: blk_q[widx] <= {bval, 24'h0};
          2'd1: blk_q[widx][23:16] <= bval;
          2'd2: blk_q[widx][15:8] <= bval;
          default: blk_q[widx][7:0] <= bval;
        endcase
      end
      if (cmd_i.clr_word) blk_q[cmd_i.zero_idx] <= '0;
      if (cmd_i.put_len) begin
        blk_q[14] <= total_q[60:29];
        blk_q[15] <= {total_q[28:0], 3'b000};
      end
    end
  end

  // control registers of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
    end else begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_d[i];
      if (cmd_i.restart) begin
        fill_q  <= '0;
        total_q <= '0;
      end else if (cmd_i.count_byte) begin
        fill_q  <= fill_q + 6'd1;
        total_q <= total_q + 64'd1;
      end else if (cmd_i.put_byte) begin
        fill_q  <= fill_q + 6'd1;
      end
      if (cmd_i.start_comp) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) v_q[i] <= v_d[i];
  end

  assign stat_o.fill = fill_q;
  assign stat_o.last_round = (rnd_q == 6'd63);
  assign head_o = h_q[0];

endmodule
`default_nettype wire

### rtl/sha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_op_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [2:0]          out_idx_o,
  input  wire sha_pkg::stat_t stat_i,
  output sha_pkg::cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPadZ  = 7'b0000010,
    StLen   = 7'b0000100,
    StLoad  = 7'b0001000,
    StRound = 7'b0010000,
    StFold  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;   // finishing a message
  logic   extra_q, extra_d; // a length block still follows
  logic [2:0] idx_q, idx_d;
  logic [3:0] zi_q, zi_d;
  logic   acc;

  assign in_ready_o  = (state_q == StIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o   = idx_q;

  // sequence absorb, padding, compression and output
  always_comb begin
    state_d = state_q;
    fin_d = fin_q;
    extra_d = extra_q;
    idx_d = idx_q;
    zi_d = zi_q;
    cmd_o = '0;
    cmd_o.zero_idx = zi_q;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.put_byte = 1'b1;
          if (in_op_i == sha_pkg::OpAbsorb) begin
            cmd_o.count_byte = 1'b1;
            fin_d = 1'b0;
            if (stat_i.fill == 6'd63) state_d = StLoad;
          end else begin
            cmd_o.byte_is_pad = 1'b1;
            fin_d = 1'b1;
            extra_d = (stat_i.fill >= 6'(sha_pkg::LenPos));
            zi_d = stat_i.fill[5:2] + 4'd1;
            state_d = (stat_i.fill[5:2] == 4'd15) ? StLoad : StPadZ;
          end
        end
      end
      StPadZ: begin
        // zero the whole words after the pad byte
        if (!extra_q && zi_q >= 4'd14) begin
          state_d = StLen;
        end else begin
          cmd_o.clr_word = 1'b1;
          zi_d = zi_q + 4'd1;
          if (zi_q == 4'd15) state_d = extra_q ? StLoad : StLen;
        end
      end
      StLen: begin
        cmd_o.put_len = 1'b1;
        state_d = StLoad;
      end
      StLoad: begin
        cmd_o.start_comp = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        if (stat_i.last_round) state_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (extra_q) begin
          extra_d = 1'b0;
          zi_d = '0;
          state_d = StPadZ;
        end else begin
          idx_d = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.shift_out = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.shift_out = 1'b0;
            cmd_o.restart = 1'b1;
            fin_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q <= 1'b0;
      extra_q <= 1'b0;
      idx_q <= '0;
      zi_q <= '0;
    end else begin
      state_q <= state_d;
      fin_q <= fin_d;
      extra_q <= extra_d;
      idx_q <= idx_d;
      zi_q <= zi_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(idx_q))
    else $error("digest word dropped");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken during output");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound && stat_i.last_round |=> state_q == StFold)
    else $error("compression overran");

endmodule
`default_nettype wire

### rtl/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 over a byte stream. The 64th byte of a block runs the compression
// unit, one round per cycle (load, 64 rounds, fold), and no further byte is
// accepted until the fold is done. A finish transaction pads (up to 15 word
// clears plus the length write), runs one or two compressions, then presents
// eight digest words, one per accepted output transaction; the last restarts
// the hash for the next message.
module sha256_stream_hasher_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);

  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;
  sha_pkg::word_t head;
  logic [2:0]     idx;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.operation),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_idx_o   (idx),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .byte_i (in_if.data_byte),
    .stat_o (stat),
    .head_o (head)
  );

  assign out_if.digest_word = head;
  assign out_if.word_index  = idx;
  assign out_if.last        = (idx == 3'd7);

endmodule
`default_nettype wire

### test/sha256_stream_hasher_core_tb.sv
`timescale 1ns / 1ps
module sha256_stream_hasher_core_tb;
  import sha_pkg::*;

  typedef struct {
    op_e   op;
    byte_t data;
  } msg_item_t;

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  localparam int unsigned CycleLimit = 500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  always #5 clk = ~clk;

  msg_item_t    pending_bytes[$];
  digest_beat_t digest_expected[$];

  // hash state of the predictor
  word_t       hash_h[8];
  byte_t       block_buf[64];
  int unsigned fill_pos;
  logic [63:0] msg_bytes;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          took = 1'b0;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // run the 64-round compression over block_buf
  task automatic compress_buf();
    word_t w[64];
    word_t v[8];
    word_t s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int t = 0; t < 8; t++) v[t] = hash_h[t];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) hash_h[t] += v[t];
  endtask

  task automatic restart_hash();
    for (int k = 0; k < 8; k++) hash_h[k] = InitH[k];
    fill_pos = 0;
    msg_bytes = '0;
  endtask

  // advance the predictor by one accepted transaction
  task automatic predict_digest(op_e op, byte_t data);
    logic [63:0]  bits;
    digest_beat_t beat;
    if (op == OpAbsorb) begin
      block_buf[fill_pos] = data;
      msg_bytes++;
      fill_pos++;
      if (fill_pos == 64) begin
        compress_buf();
        fill_pos = 0;
      end
    end else begin
      bits = msg_bytes << 3;
      block_buf[fill_pos] = PadByte;
      fill_pos++;
      if (fill_pos > LenPos) begin
        while (fill_pos < 64) block_buf[fill_pos++] = 8'h00;
        compress_buf();
        fill_pos = 0;
      end
      while (fill_pos < LenPos) block_buf[fill_pos++] = 8'h00;
      for (int k = 0; k < 8; k++) block_buf[LenPos+k] = bits[63-8*k -: 8];
      compress_buf();
      for (int k = 0; k < 8; k++) begin
        beat.word = hash_h[k];
        beat.idx  = 3'(k);
        beat.last = (k == 7);
        digest_expected.push_back(beat);
      end
      restart_hash();
    end
  endtask

  task automatic add_message(int unsigned len);
    msg_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.op = OpAbsorb;
      it.data = byte_t'($urandom);
      pending_bytes.push_back(it);
    end
    it.op = OpFinish;
    it.data = byte_t'($urandom);
    pending_bytes.push_back(it);
  endtask

  // hold the offered transaction until taken, then offer the next
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || took)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= pending_bytes[0].op;
        in_ch.data_byte <= pending_bytes[0].data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // stall the output side, with an optional long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // accept input transactions into the predictor
  always @(posedge clk) begin
    took = rst_n && in_ch.valid && in_ch.ready;
    if (took) begin
      predict_digest(op_e'(in_ch.operation), in_ch.data_byte);
      void'(pending_bytes.pop_front());
    end
  end

  // check each output transaction against the oldest expectation
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_ch.digest_word);
      end else begin
        want = digest_expected.pop_front();
        if (out_ch.digest_word !== want.word || out_ch.word_index !== want.idx ||
            out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", want.word, want.idx,
                     want.last, out_ch.digest_word, out_ch.word_index, out_ch.last);
        end
      end
    end
  end

  // end the run on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, bit squeeze);
    int unsigned pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) hold_left = 600;
    while (pending_bytes.size() < 100) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        case ($urandom_range(7))
          0: add_message(0);
          1: add_message(1);
          2: add_message(55);
          3: add_message(56);
          4: add_message(57);
          5: add_message(63);
          6: add_message(64);
          default: add_message(65);
        endcase
      end else begin
        add_message($urandom_range(40));
      end
    end
    wait (pending_bytes.size() == 0 && digest_expected.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    msg_item_t it;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    for (int k = 0; k < 64; k++) block_buf[k] = 8'h00;
    restart_hash();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty message, byte extremes, short message
    add_message(0);
    it.op = OpAbsorb;
    it.data = 8'h00;
    pending_bytes.push_back(it);
    it.op = OpFinish;
    it.data = 8'hff;
    pending_bytes.push_back(it);
    it.op = OpAbsorb;
    pending_bytes.push_back(it);
    it.op = OpFinish;
    it.data = 8'h00;
    pending_bytes.push_back(it);
    add_message(3);
    wait (pending_bytes.size() == 0 && digest_expected.size() == 0);

    run_phase(0, 0, 1'b1);
    run_phase(84, 0, 1'b0);
    run_phase(0, 84, 1'b0);
    run_phase(26, 26, 1'b0);

    wait (pending_bytes.size() == 0 && digest_expected.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hasher_core.sv
test/sha256_stream_hasher_core_tb.sv
